@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on the rising edge with an
// active-low reset that disables the check
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/scma_pkg.sv @@
// ----------------------------------------------------------------------------
// scma_pkg
// shared types and constants of the six-channel moving average
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scma_pkg;

    localparam int CHANNELS = 6;
    localparam int SAMPLE_W = 16;
    localparam int DEPTH    = 16;
    localparam int SUM_W    = 24;
    localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W    = CHANNELS * SAMPLE_W;

    // exact division by DEPTH for magnitudes below 2^SUM_W
    localparam int RECIP_K = SUM_W + $clog2(DEPTH);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP_M_L =
        ((64'd1 << RECIP_K) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_M_L[RECIP_W-1:0];

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] gyro_x;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic signed [SAMPLE_W-1:0] gyro_z;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_accel_x;
        logic signed [SAMPLE_W-1:0] mean_accel_y;
        logic signed [SAMPLE_W-1:0] mean_accel_z;
        logic signed [SAMPLE_W-1:0] mean_gyro_x;
        logic signed [SAMPLE_W-1:0] mean_gyro_y;
        logic signed [SAMPLE_W-1:0] mean_gyro_z;
    } mean_t;

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] chan_vec_t;

    // sum / DEPTH, truncated toward zero
    function automatic logic [SAMPLE_W-1:0] div_depth(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0]    mag;
        logic [PROD_W-1:0]   prod;
        logic [SAMPLE_W-1:0] q;
        mag  = s[SUM_W-1] ? $unsigned(-s) : $unsigned(s);
        prod = PROD_W'(mag) * PROD_W'(RECIP_M);
        q    = SAMPLE_W'(prod >> RECIP_K);
        return s[SUM_W-1] ? SAMPLE_W'(-q) : q;
    endfunction

endpackage

@@ src/scma_ram.sv @@
// ----------------------------------------------------------------------------
// scma_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scma_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/six_channel_moving_average.sv @@
// ----------------------------------------------------------------------------
// six_channel_moving_average
// datapath: a taken frame reads its ring row, then the sums are updated and
// snapshotted, then the divided snapshot is registered as the mean
// throughput: one frame per cycle unless mean_ready stalls; one ring ram row holds all six channels
// reset: sums, slot pointer and row valid bits clear at once; unwritten rows
// read as zero, so the block takes frames straight after reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module six_channel_moving_average
    import scma_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   frame_valid,
    output logic   frame_ready,
    input  frame_t frame,
    output logic   mean_valid,
    input  logic   mean_ready,
    output mean_t  mean
);

    // control
    logic              v1_reg, v2_reg, vo_reg;
    logic              accept, move2, move_o;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [DEPTH-1:0]  row_valid_reg;
    logic              hz_reg, rv_reg;

    // payload
    chan_vec_t               s1_new_reg;
    chan_vec_t               fwd_reg;
    chan_vec_t               old_v;
    logic [ROW_W-1:0]        ram_rdata;
    logic signed [SUM_W-1:0] sum_reg  [CHANNELS];
    logic signed [SUM_W-1:0] sum_next [CHANNELS];
    logic signed [SUM_W-1:0] snap_reg [CHANNELS];
    chan_vec_t               mean_v;
    chan_vec_t               out_reg;

    assign move_o      = v2_reg && (!vo_reg || mean_ready);
    assign move2       = v1_reg && (!v2_reg || move_o);
    assign frame_ready = !v1_reg || move2;
    assign accept      = frame_valid && frame_ready;

    assign rd_slot_next = (rd_slot_reg == SLOT_W'(DEPTH - 1)) ? '0 : rd_slot_reg + 1'b1;

    scma_ram #(
        .WIDTH (ROW_W),
        .WORDS (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (move2),
        .waddr (s1_slot_reg),
        .wdata (s1_new_reg),
        .re    (accept),
        .raddr (rd_slot_reg),
        .rdata (ram_rdata)
    );

    // oldest samples: forwarded row on a same-row overlap, zero if never written
    always_comb
    begin
        if (hz_reg)
        begin
            old_v = fwd_reg;
        end
        else if (rv_reg)
        begin
            old_v = chan_vec_t'(ram_rdata);
        end
        else
        begin
            old_v = '0;
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_next[c] = sum_reg[c] - SUM_W'($signed(old_v[c]))
                          + SUM_W'($signed(s1_new_reg[c]));
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            mean_v[c] = div_depth(snap_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            vo_reg        <= 1'b0;
            rd_slot_reg   <= '0;
            row_valid_reg <= '0;
            hz_reg        <= 1'b0;
            rv_reg        <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
            end
        end
        else
        begin
            if (frame_ready)
            begin
                v1_reg <= accept;
            end
            if (!v2_reg || move_o)
            begin
                v2_reg <= move2;
            end
            if (!vo_reg || mean_ready)
            begin
                vo_reg <= move_o;
            end
            if (accept)
            begin
                rd_slot_reg <= rd_slot_next;
                hz_reg      <= move2 && (s1_slot_reg == rd_slot_reg);
                rv_reg      <= row_valid_reg[rd_slot_reg];
            end
            if (move2)
            begin
                row_valid_reg[s1_slot_reg] <= 1'b1;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    sum_reg[c] <= sum_next[c];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_new_reg  <= chan_vec_t'(frame);
            s1_slot_reg <= rd_slot_reg;
            fwd_reg     <= s1_new_reg;
        end
        if (move2)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                snap_reg[c] <= sum_next[c];
            end
        end
        if (move_o)
        begin
            out_reg <= mean_v;
        end
    end

    assign mean_valid = vo_reg;
    assign mean       = mean_t'(out_reg);

endmodule

@@ src/scma_checker.sv @@
// ----------------------------------------------------------------------------
// scma_checker
// port-level checks on the six-channel moving average
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module scma_checker
    import scma_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   frame_valid,
    input logic   frame_ready,
    input frame_t frame,
    input logic   mean_valid,
    input logic   mean_ready,
    input mean_t  mean
);

    // an empty output stage never back-pressures the input
    `ASSERT_SAME(a_ready_when_empty, clk, rst_n, !mean_valid, frame_ready, "ready low with output empty")

    // a waiting frame stays offered with its payload unchanged
    `ASSERT_NEXT(a_in_hold, clk, rst_n, frame_valid && !frame_ready, frame_valid && $stable(frame), "stalled frame changed")

    // a stalled mean stays and holds its value
    `ASSERT_NEXT(a_out_hold, clk, rst_n, mean_valid && !mean_ready, mean_valid && $stable(mean), "stalled mean changed")

    // a frame accepted while the output is empty and not ready is followed by frame_ready or mean_valid
    `ASSERT_NEXT(a_accept_flows, clk, rst_n, frame_valid && frame_ready && !mean_valid && !mean_ready, frame_ready || mean_valid, "accepted frame lost")

endmodule

bind six_channel_moving_average scma_checker u_scma_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .mean_valid  (mean_valid),
    .mean_ready  (mean_ready),
    .mean        (mean)
);

@@ test/tb_six_channel_moving_average.sv @@
// ----------------------------------------------------------------------------
// tb_six_channel_moving_average
// self-checking bench for the six-channel boxcar average: a short table of
// corner frames, then random runs of frames. Each mean item is checked
// field by field against a running-sum model in the bench or a value typed into
// the table, with random bursts on the frame side and random stalls on the mean side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_six_channel_moving_average;
    import scma_pkg::*;

    localparam int FRAME_COUNT    = 1900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    typedef struct {
        frame_t      samples;
        int unsigned reps;
        bit          fixed;
        mean_t       want;
    } stim_row_t;

    logic   clk;
    logic   rst_n;
    logic   frame_valid;
    logic   frame_ready;
    frame_t frame;
    logic   mean_valid;
    logic   mean_ready;
    mean_t  mean;

    // expectation typed into the table travels alongside the frame
    logic   fixed_valid;
    mean_t  fixed_mean;

    // window model
    logic signed [SAMPLE_W-1:0] window_ring [CHANNELS][DEPTH];
    int                         window_sum [CHANNELS];
    int unsigned                next_slot;

    mean_t       expected_means[$];
    stim_row_t   directed_rows[$];
    int unsigned mismatches;
    int unsigned frames_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;
    int unsigned stall_mode;
    int unsigned stall_phase;

    mean_t     predicted;
    mean_t     oldest_mean;
    chan_vec_t want_v;
    chan_vec_t got_v;

    string chan_names [CHANNELS] = '{"mean_accel_x", "mean_accel_y", "mean_accel_z",
                                     "mean_gyro_x", "mean_gyro_y", "mean_gyro_z"};

    six_channel_moving_average i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .mean_valid  (mean_valid),
        .mean_ready  (mean_ready),
        .mean        (mean)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // newest sample replaces the oldest, sums kept exact, mean truncates toward zero
    function automatic mean_t average_frame(input frame_t f);
        chan_vec_t   samples;
        chan_vec_t   means;
        int          s;
        int          q;
        samples = chan_vec_t'(f);
        for (int c = 0; c < CHANNELS; c++)
        begin
            s = $signed(samples[CHANNELS-1-c]);
            window_sum[c] = window_sum[c] - window_ring[c][next_slot] + s;
            window_ring[c][next_slot] = s[SAMPLE_W-1:0];
            q = window_sum[c] / DEPTH;
            means[CHANNELS-1-c] = q[SAMPLE_W-1:0];
        end
        next_slot = (next_slot + 1 >= DEPTH) ? 0 : next_slot + 1;
        return mean_t'(means);
    endfunction

    function automatic stim_row_t mk_row(input frame_t f, input int unsigned reps,
                                         input bit fixed, input mean_t want);
        stim_row_t r;
        r.samples = f;
        r.reps    = reps;
        r.fixed   = fixed;
        r.want    = want;
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_frame(input frame_t f, input bit fixed, input mean_t want);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0)
            begin
                frame_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        frame_valid <= 1'b1;
        frame       <= f;
        fixed_valid <= fixed;
        fixed_mean  <= want;
        do @(posedge clk); while (!frame_ready);
        frames_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_means;
        frame_valid <= 1'b0;
        while (expected_means.size() != 0) @(negedge clk);
    endtask

    // receiver stall pattern, switching to a random mode when its phase counter runs out
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(8, 80);
        end
        else
        begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0:       mean_ready <= 1'b1;
            1:       mean_ready <= ($urandom_range(0, 3) != 0);
            2:       mean_ready <= (stall_phase[2:0] == 3'd0);
            default: mean_ready <= $urandom_range(0, 1);
        endcase
    end

    // prediction on every frame taken, check on every mean taken, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_valid && frame_ready)
            begin
                predicted = average_frame(frame);
                expected_means.push_back(fixed_valid ? fixed_mean : predicted);
            end
            if (mean_valid && mean_ready)
            begin
                if (expected_means.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected mean item: expected none, actual %h", $time, mean);
                end
                else
                begin
                    oldest_mean = expected_means.pop_front();
                    want_v = chan_vec_t'(oldest_mean);
                    got_v  = chan_vec_t'(mean);
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (got_v[CHANNELS-1-c] !== want_v[CHANNELS-1-c])
                        begin
                            mismatches++;
                            $display("%0t mismatch on %s: expected %0d actual %0d", $time,
                                     chan_names[c], $signed(want_v[CHANNELS-1-c]),
                                     $signed(got_v[CHANNELS-1-c]));
                        end
                    end
                end
            end
        end
        if ((frame_valid && frame_ready) || (mean_valid && mean_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        frame_t              f;
        chan_vec_t           v;
        logic [CHANNELS-1:0] pol;
        int unsigned         kind;
        int unsigned         run;
        bit                  mid_drain_done;

        clk         = 1'b0;
        rst_n       = 1'b0;
        frame_valid = 1'b0;
        frame       = '0;
        fixed_valid = 1'b0;
        fixed_mean  = '0;
        mean_ready  = 1'b0;
        mismatches  = 0;
        frames_sent = 0;
        burst_left  = 0;
        idle_cycles = 0;
        stall_mode  = 0;
        stall_phase = 0;
        next_slot   = 0;
        mid_drain_done = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            window_sum[c] = 0;
            for (int d = 0; d < DEPTH; d++)
                window_ring[c][d] = '0;
        end

        // first frame after reset sees a window of zeros
        directed_rows.push_back(mk_row(frame_t'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1,
            1'b1, mean_t'{16'sd2047, 16'sd2047, 16'sd2047, 16'sd2047, 16'sd2047, 16'sd2047}));
        // sum of -1 truncates toward zero, not down to -1
        directed_rows.push_back(mk_row(frame_t'{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}, 1,
            1'b1, mean_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}));
        directed_rows.push_back(mk_row(frame_t'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
            -16'sd1}, 1, 1'b0, '0));
        directed_rows.push_back(mk_row(frame_t'{S_MAX, S_MIN, 16'sd0, -16'sd1, 16'sd1,
            -16'sd16}, 1, 1'b0, '0));
        directed_rows.push_back(mk_row(frame_t'{16'shaaaa, 16'shaaaa, 16'shaaaa, 16'shaaaa,
            16'shaaaa, 16'shaaaa}, 1, 1'b0, '0));
        directed_rows.push_back(mk_row(frame_t'{16'sh5555, 16'sh5555, 16'sh5555, 16'sh5555,
            16'sh5555, 16'sh5555}, 1, 1'b0, '0));
        directed_rows.push_back(mk_row(frame_t'{-16'sd15, -16'sd17, -16'sd31, -16'sd33, 16'sd15,
            16'sd17}, 1, 1'b0, '0));
        // fill the whole window with full scale, wrapping the write slot
        directed_rows.push_back(mk_row(frame_t'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX},
            DEPTH, 1'b0, '0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            repeat (directed_rows[i].reps)
                send_frame(directed_rows[i].samples, directed_rows[i].fixed,
                           directed_rows[i].want);
        end
        wait_for_means();

        while (frames_sent < FRAME_COUNT)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                6:       run = DEPTH + $urandom_range(0, 8);
                7:       run = $urandom_range(1, 40);
                8:       run = $urandom_range(1, 30);
                default: run = $urandom_range(1, 60);
            endcase
            // per-channel polarity for full-window extreme runs
            pol = CHANNELS'($urandom_range(0, 63));
            for (int c = 0; c < CHANNELS; c++)
                v[c] = pol[c] ? S_MAX : S_MIN;
            repeat (run)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    case (kind)
                        6: ;
                        7: v[c] = 16'($urandom_range(0, 40)) - 16'd20;
                        8:
                        begin
                            case ($urandom_range(0, 5))
                                0:       v[c] = S_MAX;
                                1:       v[c] = S_MIN;
                                2:       v[c] = '0;
                                3:       v[c] = '1;
                                4:       v[c] = 16'd1;
                                default: v[c] = 16'($urandom);
                            endcase
                        end
                        default: v[c] = 16'($urandom);
                    endcase
                end
                f = frame_t'(v);
                send_frame(f, 1'b0, '0);
            end
            if (!mid_drain_done && frames_sent >= FRAME_COUNT / 2)
            begin
                wait_for_means();
                mid_drain_done = 1'b1;
            end
        end

        wait_for_means();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_means.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
